// ----- rtl/imd_pkg.sv -----
`default_nettype none

package imd_pkg;

   localparam int BUFFER_BYTES = 1048576;
   localparam int COUNT_WIDTH  = $clog2(BUFFER_BYTES + 1);
   localparam int HEADER_LEN   = 12;
   localparam int HCOUNT_WIDTH = $clog2(HEADER_LEN);
   localparam int MAX_RESULTS  = 4;

   localparam logic [7:0]  MARK_TYPE         = 8'hAB;
   localparam logic [7:0]  MARK_STAMP        = 8'hAA;
   localparam logic [31:0] TERMINATOR        = 32'h0D0A0D0A;
   localparam logic [15:0] RESET_STREAM_TYPE = 16'd263;

   localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
   localparam logic [2:0] KIND_EMPTY     = 3'd1;
   localparam logic [2:0] KIND_TEXT      = 3'd2;
   localparam logic [2:0] KIND_ABANDONED = 3'd3;
   localparam logic [2:0] KIND_LEN_ERROR = 3'd4;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEAD,
      PH_PAY,
      PH_TEXT
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  out_byte;
      logic [15:0] stream_id;
      logic        fresh_type;
      logic [31:0] stamp;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [2:0]                   count;
      result_type [MAX_RESULTS-1:0] item;
   } batch_type;

endpackage

`default_nettype wire

// ----- rtl/imd_req_if.sv -----
`default_nettype none

interface imd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/imd_rsp_if.sv -----
`default_nettype none

interface imd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  out_byte;
   logic [15:0] stream_id;
   logic        fresh_type;
   logic [31:0] stamp;
   logic        last;

   modport source (output valid, output kind, output out_byte, output stream_id,
                   output fresh_type, output stamp, output last, input ready);
   modport sink (input valid, input kind, input out_byte, input stream_id,
                 input fresh_type, input stamp, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/imd_parser.sv -----
`default_nettype none

module imd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         data_byte,
   output imd_pkg::batch_type      batch
);

   imd_pkg::phase_type phase_ff, phase_in;
   logic [7:0] header_ff [imd_pkg::HEADER_LEN];
   logic [7:0] hb_in [imd_pkg::HEADER_LEN];
   logic [imd_pkg::HCOUNT_WIDTH-1:0] header_count_ff, header_count_in;
   logic [15:0] saved_type_ff, saved_type_in;
   logic [31:0] saved_seconds_ff, saved_seconds_in;
   logic [15:0] tag_stream_ff, tag_stream_in;
   logic        tag_fresh_ff, tag_fresh_in;
   logic [31:0] tag_stamp_ff, tag_stamp_in;
   logic [imd_pkg::COUNT_WIDTH-1:0] bytes_left_ff, bytes_left_in;
   logic [imd_pkg::COUNT_WIDTH-1:0] text_count_ff, text_count_in;
   logic [31:0] tail_ff, tail_in;

   logic        hunt_done, head_done, marker_hit, type_hdr;
   logic        len_bad, len_zero, text_full, text_term;
   logic [31:0] open_window, len_word, field_word, tail_shift;
   logic [imd_pkg::COUNT_WIDTH-1:0] left_dec, count_inc;
   logic [15:0] new_stream;
   logic        new_fresh;
   logic [31:0] new_stamp;

   always_comb begin
      hb_in = header_ff;
      if (phase_ff == imd_pkg::PH_HUNT) begin
         hb_in[header_count_ff] = data_byte;
      end else if (phase_ff == imd_pkg::PH_HEAD) begin
         hb_in[header_count_ff] = data_byte;
      end
   end

   assign hunt_done   = (header_count_ff[1:0] == 2'd3);
   assign head_done   = (header_count_ff == imd_pkg::HCOUNT_WIDTH'(imd_pkg::HEADER_LEN - 1));
   assign marker_hit  = (hb_in[0] == imd_pkg::MARK_TYPE || hb_in[0] == imd_pkg::MARK_STAMP)
                        && hb_in[1] == imd_pkg::MARK_STAMP && hb_in[2] == 8'h00
                        && hb_in[3] == 8'h00;
   assign open_window = {hb_in[0], hb_in[1], hb_in[2], hb_in[3]};
   assign len_word    = {hb_in[7], hb_in[6], hb_in[5], hb_in[4]};
   assign field_word  = {hb_in[11], hb_in[10], hb_in[9], hb_in[8]};
   assign type_hdr    = (hb_in[0] == imd_pkg::MARK_TYPE);
   assign len_bad     = (len_word > 32'(imd_pkg::BUFFER_BYTES));
   assign len_zero    = (len_word == 32'd0);
   assign left_dec    = bytes_left_ff - imd_pkg::COUNT_WIDTH'(1);
   assign count_inc   = text_count_ff + imd_pkg::COUNT_WIDTH'(1);
   assign text_full   = (count_inc >= imd_pkg::COUNT_WIDTH'(imd_pkg::BUFFER_BYTES - 8));
   assign tail_shift  = {tail_ff[23:0], data_byte};
   assign text_term   = (tail_shift == imd_pkg::TERMINATOR);
   assign new_stream  = type_hdr ? field_word[15:0] : saved_type_ff;
   assign new_fresh   = type_hdr;
   assign new_stamp   = type_hdr ? saved_seconds_ff : field_word;

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         imd_pkg::PH_HUNT: begin
            if (hunt_done) begin
               if (marker_hit) begin
                  phase_in = imd_pkg::PH_HEAD;
               end else if (open_window == imd_pkg::TERMINATOR) begin
                  phase_in = imd_pkg::PH_HUNT;
               end else begin
                  phase_in = imd_pkg::PH_TEXT;
               end
            end
         end
         imd_pkg::PH_HEAD: begin
            if (head_done) begin
               phase_in = (!len_bad && !len_zero) ? imd_pkg::PH_PAY : imd_pkg::PH_HUNT;
            end
         end
         imd_pkg::PH_PAY: begin
            if (left_dec == '0) begin
               phase_in = imd_pkg::PH_HUNT;
            end
         end
         imd_pkg::PH_TEXT: begin
            if (text_full || text_term) begin
               phase_in = imd_pkg::PH_HUNT;
            end
         end
         default: phase_in = imd_pkg::PH_HUNT;
      endcase
   end

   always_comb begin
      header_count_in  = header_count_ff;
      saved_type_in    = saved_type_ff;
      saved_seconds_in = saved_seconds_ff;
      tag_stream_in    = tag_stream_ff;
      tag_fresh_in     = tag_fresh_ff;
      tag_stamp_in     = tag_stamp_ff;
      bytes_left_in    = bytes_left_ff;
      text_count_in    = text_count_ff;
      tail_in          = tail_ff;
      batch            = '0;
      case (phase_ff)
         imd_pkg::PH_HUNT: begin
            header_count_in = {{(imd_pkg::HCOUNT_WIDTH-2){1'b0}},
                               header_count_ff[1:0] + 2'd1};
            if (hunt_done) begin
               if (marker_hit) begin
                  header_count_in = imd_pkg::HCOUNT_WIDTH'(4);
               end else begin
                  tail_in       = open_window;
                  text_count_in = '0;
                  batch.count   = 3'd4;
                  for (int i = 0; i < imd_pkg::MAX_RESULTS; i++) begin
                     batch.item[i].kind     = imd_pkg::KIND_TEXT;
                     batch.item[i].out_byte = hb_in[i];
                  end
                  batch.item[3].last = (open_window == imd_pkg::TERMINATOR);
               end
            end
         end
         imd_pkg::PH_HEAD: begin
            header_count_in = header_count_ff + imd_pkg::HCOUNT_WIDTH'(1);
            if (head_done) begin
               header_count_in = '0;
               tag_stream_in   = new_stream;
               tag_fresh_in    = new_fresh;
               tag_stamp_in    = new_stamp;
               if (type_hdr) begin
                  saved_type_in = field_word[15:0];
               end else begin
                  saved_seconds_in = field_word;
               end
               if (len_bad) begin
                  batch.count        = 3'd1;
                  batch.item[0].kind = imd_pkg::KIND_LEN_ERROR;
               end else if (len_zero) begin
                  batch.count              = 3'd1;
                  batch.item[0].kind       = imd_pkg::KIND_EMPTY;
                  batch.item[0].stream_id  = new_stream;
                  batch.item[0].fresh_type = new_fresh;
                  batch.item[0].stamp      = new_stamp;
                  batch.item[0].last       = 1'b1;
               end else begin
                  bytes_left_in = len_word[imd_pkg::COUNT_WIDTH-1:0];
               end
            end
         end
         imd_pkg::PH_PAY: begin
            bytes_left_in            = left_dec;
            batch.count              = 3'd1;
            batch.item[0].kind       = imd_pkg::KIND_PAYLOAD;
            batch.item[0].out_byte   = data_byte;
            batch.item[0].stream_id  = tag_stream_ff;
            batch.item[0].fresh_type = tag_fresh_ff;
            batch.item[0].stamp      = tag_stamp_ff;
            batch.item[0].last       = (left_dec == '0);
         end
         imd_pkg::PH_TEXT: begin
            tail_in                = tail_shift;
            text_count_in          = count_inc;
            batch.item[0].kind     = imd_pkg::KIND_TEXT;
            batch.item[0].out_byte = data_byte;
            if (text_full) begin
               batch.count        = 3'd2;
               batch.item[1].kind = imd_pkg::KIND_ABANDONED;
               batch.item[1].last = 1'b1;
            end else begin
               batch.count        = 3'd1;
               batch.item[0].last = text_term;
            end
         end
         default: begin
            header_count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= imd_pkg::PH_HUNT;
         header_count_ff  <= '0;
         saved_type_ff    <= imd_pkg::RESET_STREAM_TYPE;
         saved_seconds_ff <= '0;
         tag_stream_ff    <= '0;
         tag_fresh_ff     <= 1'b0;
         tag_stamp_ff     <= '0;
         bytes_left_ff    <= '0;
         text_count_ff    <= '0;
         tail_ff          <= '0;
         for (int i = 0; i < imd_pkg::HEADER_LEN; i++) begin
            header_ff[i] <= 8'h00;
         end
      end else if (accept) begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         saved_type_ff    <= saved_type_in;
         saved_seconds_ff <= saved_seconds_in;
         tag_stream_ff    <= tag_stream_in;
         tag_fresh_ff     <= tag_fresh_in;
         tag_stamp_ff     <= tag_stamp_in;
         bytes_left_ff    <= bytes_left_in;
         text_count_ff    <= text_count_in;
         tail_ff          <= tail_in;
         header_ff        <= hb_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/interleaved_media_deframer_top.sv -----
// Interleaved media deframer. The req_channel carries one received byte per beat; the
// rsp_channel carries result beats (payload byte, empty packet, text byte, text
// abandoned, length error) tagged with stream type, fresh flag and timestamp.
// Each accepted byte is parsed in the cycle it is accepted, and its results are
// loaded into a four-entry output queue, so the first result of a byte is offered
// in the cycle after that byte is accepted.
// Throughput is one byte per cycle while each byte gives at most one result and
// the receiver takes each result as it is offered. A byte that closes a non-marker
// four-byte group gives four text results and a byte that hits the text limit gives
// two; req_channel.ready stays low until all but the last of them have left. The
// output queue sets this: a new byte is taken only once the queue is empty or its
// last entry leaves in the same cycle.
// When the receiver stalls, the queue holds its entries and ready falls as soon
// as the queue cannot drain in the current cycle.
// Synchronous reset empties the queue and returns the parser to hunting for a
// marker, with the stored stream type set to 263 and the timestamp cleared.
`default_nettype none

module interleaved_media_deframer_top (
   input wire logic  clock,
   input wire logic  reset,
   imd_req_if.sink   req_channel,
   imd_rsp_if.source rsp_channel
);

   imd_pkg::batch_type batch;
   imd_pkg::result_type [imd_pkg::MAX_RESULTS-1:0] slot_ff, slot_in;
   logic [2:0] count_ff, count_in;
   logic       in_accept, out_pop;

   assign out_pop   = rsp_channel.valid && rsp_channel.ready;
   assign req_channel.ready = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_channel.ready);
   assign in_accept = req_channel.valid && req_channel.ready;

   imd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (in_accept),
      .data_byte (req_channel.data_byte),
      .batch     (batch)
   );

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (in_accept) begin
         slot_in  = batch.item;
         count_in = batch.count;
      end else if (out_pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         slot_in[2] = slot_ff[3];
         count_in   = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign rsp_channel.valid      = (count_ff != 3'd0);
   assign rsp_channel.kind       = slot_ff[0].kind;
   assign rsp_channel.out_byte   = slot_ff[0].out_byte;
   assign rsp_channel.stream_id  = slot_ff[0].stream_id;
   assign rsp_channel.fresh_type = slot_ff[0].fresh_type;
   assign rsp_channel.stamp      = slot_ff[0].stamp;
   assign rsp_channel.last       = slot_ff[0].last;

endmodule

`default_nettype wire

// ----- test/interleaved_media_deframer_top_tb.sv -----
`timescale 1ns / 1ps

module interleaved_media_deframer_top_tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_BYTES   = 10;

   logic clock = 1'b0;
   logic reset;

   imd_req_if req_bus ();
   imd_rsp_if rsp_bus ();

   interleaved_media_deframer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus)
   );

   imd_pkg::result_type expected_results [$];
   imd_pkg::result_type seen_result;
   imd_pkg::result_type want_result;
   int errors;
   int sent_bytes;
   int send_idle_pct;
   int rsp_stall_pct;
   int hold_left;
   int idle_cycles;

   imd_pkg::phase_type pr_phase;
   logic [7:0]       pr_hdr [imd_pkg::HEADER_LEN];
   logic [3:0]       pr_count;
   logic [15:0]      pr_saved_type;
   logic [31:0]      pr_saved_seconds;
   logic [15:0]      pr_tag_stream;
   logic             pr_tag_fresh;
   logic [31:0]      pr_tag_stamp;
   logic [20:0]      pr_bytes_left;
   logic [20:0]      pr_text_count;
   logic [31:0]      pr_tail;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic imd_pkg::result_type make_result(input logic [2:0] kind,
                                                       input logic [7:0] value,
                                                       input logic [15:0] stream,
                                                       input logic fresh,
                                                       input logic [31:0] stamp,
                                                       input logic last);
      imd_pkg::result_type r;
      r.kind       = kind;
      r.out_byte   = value;
      r.stream_id  = stream;
      r.fresh_type = fresh;
      r.stamp      = stamp;
      r.last       = last;
      return r;
   endfunction

   task automatic deframe_byte(input logic [7:0] value);
      logic [31:0] len_word;
      logic [31:0] tag_word;
      logic        done;
      case (pr_phase)
         imd_pkg::PH_HUNT: begin
            pr_hdr[pr_count] = value;
            pr_count = (pr_count + 4'd1) & 4'd3;
            if (pr_count == 4'd0) begin
               if ((pr_hdr[0] == imd_pkg::MARK_TYPE || pr_hdr[0] == imd_pkg::MARK_STAMP) &&
                   pr_hdr[1] == imd_pkg::MARK_STAMP && pr_hdr[2] == 8'h00 &&
                   pr_hdr[3] == 8'h00) begin
                  pr_count = 4'd4;
                  pr_phase = imd_pkg::PH_HEAD;
               end else begin
                  pr_tail = {pr_hdr[0], pr_hdr[1], pr_hdr[2], pr_hdr[3]};
                  pr_text_count = '0;
                  done = (pr_tail == imd_pkg::TERMINATOR);
                  for (int i = 0; i < 4; i++) begin
                     expected_results.push_back(make_result(imd_pkg::KIND_TEXT, pr_hdr[i],
                                                            16'h0, 1'b0, 32'h0,
                                                            done && i == 3));
                  end
                  pr_phase = done ? imd_pkg::PH_HUNT : imd_pkg::PH_TEXT;
               end
            end
         end
         imd_pkg::PH_HEAD: begin
            pr_hdr[pr_count] = value;
            pr_count = pr_count + 4'd1;
            if (pr_count == 4'(imd_pkg::HEADER_LEN)) begin
               pr_count = 4'd0;
               len_word = {pr_hdr[7], pr_hdr[6], pr_hdr[5], pr_hdr[4]};
               tag_word = {pr_hdr[11], pr_hdr[10], pr_hdr[9], pr_hdr[8]};
               if (pr_hdr[0] == imd_pkg::MARK_TYPE) begin
                  pr_saved_type = tag_word[15:0];
                  pr_tag_stream = pr_saved_type;
                  pr_tag_fresh  = 1'b1;
                  pr_tag_stamp  = pr_saved_seconds;
               end else begin
                  pr_saved_seconds = tag_word;
                  pr_tag_stream    = pr_saved_type;
                  pr_tag_fresh     = 1'b0;
                  pr_tag_stamp     = tag_word;
               end
               pr_phase = imd_pkg::PH_HUNT;
               if (len_word > 32'(imd_pkg::BUFFER_BYTES)) begin
                  expected_results.push_back(make_result(imd_pkg::KIND_LEN_ERROR, 8'h0,
                                                         16'h0, 1'b0, 32'h0, 1'b0));
               end else if (len_word == 32'h0) begin
                  expected_results.push_back(make_result(imd_pkg::KIND_EMPTY, 8'h0,
                                                         pr_tag_stream, pr_tag_fresh,
                                                         pr_tag_stamp, 1'b1));
               end else begin
                  pr_bytes_left = len_word[20:0];
                  pr_phase = imd_pkg::PH_PAY;
               end
            end
         end
         imd_pkg::PH_PAY: begin
            pr_bytes_left = pr_bytes_left - 21'd1;
            expected_results.push_back(make_result(imd_pkg::KIND_PAYLOAD, value,
                                                   pr_tag_stream, pr_tag_fresh,
                                                   pr_tag_stamp, pr_bytes_left == 21'd0));
            if (pr_bytes_left == 21'd0) begin
               pr_phase = imd_pkg::PH_HUNT;
            end
         end
         default: begin
            pr_tail = {pr_tail[23:0], value};
            pr_text_count = pr_text_count + 21'd1;
            if (int'(pr_text_count) + 8 >= imd_pkg::BUFFER_BYTES) begin
               expected_results.push_back(make_result(imd_pkg::KIND_TEXT, value, 16'h0,
                                                      1'b0, 32'h0, 1'b0));
               expected_results.push_back(make_result(imd_pkg::KIND_ABANDONED, 8'h0, 16'h0,
                                                      1'b0, 32'h0, 1'b1));
               pr_phase = imd_pkg::PH_HUNT;
            end else if (pr_tail == imd_pkg::TERMINATOR) begin
               expected_results.push_back(make_result(imd_pkg::KIND_TEXT, value, 16'h0,
                                                      1'b0, 32'h0, 1'b1));
               pr_phase = imd_pkg::PH_HUNT;
            end else begin
               expected_results.push_back(make_result(imd_pkg::KIND_TEXT, value, 16'h0,
                                                      1'b0, 32'h0, 1'b0));
            end
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = 0;
      if (send_idle_pct > 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            gap++;
         end
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      do @(posedge clock); while (!req_bus.ready);
      deframe_byte(value);
      sent_bytes++;
   endtask

   task automatic send_group(input logic [31:0] group);
      for (int i = 3; i >= 0; i--) begin
         send_byte(group[i*8 +: 8]);
      end
   endtask

   task automatic send_le_word(input logic [31:0] word);
      for (int i = 0; i < 4; i++) begin
         send_byte(word[i*8 +: 8]);
      end
   endtask

   task automatic send_packet(input logic [7:0] mark, input logic [31:0] len_word,
                              input logic [31:0] tag_word);
      send_group({mark, imd_pkg::MARK_STAMP, 16'h0000});
      send_le_word(len_word);
      send_le_word(tag_word);
      if (len_word <= 32'(imd_pkg::BUFFER_BYTES)) begin
         for (int i = 0; i < int'(len_word); i++) begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic send_text_block(input int body_len);
      send_group($urandom);
      for (int i = 0; i < body_len; i++) begin
         send_byte(8'($urandom_range(0, 255)));
      end
      send_group(imd_pkg::TERMINATOR);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Brings the parser back to the start of a four-byte group in hunting.
   task automatic sync_to_hunt();
      while (!(pr_phase == imd_pkg::PH_HUNT && pr_count == 4'd0)) begin
         case (pr_phase)
            imd_pkg::PH_TEXT: send_byte(pr_tail[7:0] == 8'h0D ? 8'h0A : 8'h0D);
            imd_pkg::PH_HEAD: send_byte(8'h00);
            imd_pkg::PH_PAY:  send_byte(8'($urandom_range(0, 255)));
            default:          send_byte(8'h0D);
         endcase
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_group(imd_pkg::TERMINATOR);
      send_group(32'h47455420);
      send_byte(8'h78);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_group(imd_pkg::TERMINATOR);
      send_packet(imd_pkg::MARK_TYPE, 32'd3, 32'h12345678);
      send_packet(imd_pkg::MARK_STAMP, 32'd0, 32'hFFFFFFFF);
      send_packet(imd_pkg::MARK_TYPE, 32'(imd_pkg::BUFFER_BYTES) + 32'd1, 32'h0000BEEF);
      send_packet(imd_pkg::MARK_STAMP, 32'hFFFFFFFF, 32'h00000001);
      send_packet(imd_pkg::MARK_STAMP, 32'd1, 32'h11223344);
      send_packet(imd_pkg::MARK_TYPE, 32'd0, 32'hFFFF0000);
      send_group({imd_pkg::MARK_TYPE, imd_pkg::MARK_STAMP, 16'h0001});
      send_group(imd_pkg::TERMINATOR);
      wait_drained();
   endtask

   task automatic test_output_hold_off();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left = 300;
      send_text_block(8);
      send_packet(imd_pkg::MARK_STAMP, 32'd6, $urandom);
      wait_drained();
      send_packet(imd_pkg::MARK_TYPE, 32'd2, $urandom);
      wait_drained();
   endtask

   task automatic test_random(input int idle_pct, input int stall_pct);
      int start;
      int pick;
      logic [31:0] len_word;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = sent_bytes;
      while (sent_bytes - start < RANDOM_BYTES) begin
         sync_to_hunt();
         if ($urandom_range(9) == 0) begin
            wait_drained();
         end
         pick = $urandom_range(99);
         if (pick < 50) begin
            case ($urandom_range(9))
               0:       len_word = 32'd0;
               1:       len_word = 32'(imd_pkg::BUFFER_BYTES) + 32'd1;
               2:       len_word = $urandom | 32'h80000000;
               3:       len_word = 32'($urandom_range(16, 40));
               default: len_word = 32'($urandom_range(1, 8));
            endcase
            send_packet($urandom_range(1) ? imd_pkg::MARK_TYPE : imd_pkg::MARK_STAMP,
                        len_word, $urandom);
         end else if (pick < 72) begin
            send_text_block($urandom_range(0, 10));
         end else if (pick < 86) begin
            repeat ($urandom_range(1, 7)) send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 93) begin
            send_byte($urandom_range(1) ? imd_pkg::MARK_TYPE : imd_pkg::MARK_STAMP);
            send_byte(imd_pkg::MARK_STAMP);
            send_byte(8'h00);
            send_byte(8'($urandom_range(1, 255)));
         end else begin
            send_group({imd_pkg::MARK_STAMP, imd_pkg::MARK_STAMP, 16'h0000});
            send_byte(8'($urandom_range(0, 255)));
         end
      end
      sync_to_hunt();
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_result = make_result(rsp_bus.kind, rsp_bus.out_byte, rsp_bus.stream_id,
                                   rsp_bus.fresh_type, rsp_bus.stamp, rsp_bus.last);
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: expected no result beat, actual kind %0d byte %02h", $time,
                     seen_result.kind, seen_result.out_byte);
         end else begin
            want_result = expected_results.pop_front();
            if (seen_result !== want_result) begin
               errors++;
               $display({"%0t: expected kind %0d byte %02h stream %04h fresh %0d",
                         " stamp %08h last %0d"},
                        $time, want_result.kind, want_result.out_byte,
                        want_result.stream_id, want_result.fresh_type,
                        want_result.stamp, want_result.last);
               $display({"%0t:   actual kind %0d byte %02h stream %04h fresh %0d",
                         " stamp %08h last %0d"},
                        $time, seen_result.kind, seen_result.out_byte,
                        seen_result.stream_id, seen_result.fresh_type,
                        seen_result.stamp, seen_result.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("interleaved_media_deframer_top_tb: errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      errors        = 0;
      sent_bytes    = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left     = 0;
      idle_cycles   = 0;
      pr_phase         = imd_pkg::PH_HUNT;
      pr_count         = 4'd0;
      pr_saved_type    = imd_pkg::RESET_STREAM_TYPE;
      pr_saved_seconds = 32'h0;
      pr_tag_stream    = 16'h0;
      pr_tag_fresh     = 1'b0;
      pr_tag_stamp     = 32'h0;
      pr_bytes_left    = '0;
      pr_text_count    = '0;
      pr_tail          = 32'h0;
      for (int i = 0; i < imd_pkg::HEADER_LEN; i++) begin
         pr_hdr[i] = 8'h00;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_output_hold_off();
      test_random(0, 0);
      test_random(78, 0);
      test_random(0, 78);
      test_random(21, 21);

      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("interleaved_media_deframer_top_tb: clean");
      end else begin
         $display("interleaved_media_deframer_top_tb: errors");
      end
      $finish;
   end

endmodule
